### rtl/slrd_pkg.sv
`timescale 1ns / 1ps
package slrd_pkg;

   localparam int DATA_W      = 16;
   localparam int LOSS_W      = 40;
   localparam int COUNT_W     = 25;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int MAX_ELEMENTS = 16777216;

   localparam int DIV_NUM_W = LOSS_W + 1;
   localparam int DIV_DEN_W = COUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_ELEM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BETA = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = 1'b1;

   localparam logic [DATA_W-1:0] BETA_RESET = 16'd256;
   localparam logic [LOSS_W-1:0] SUM_MAX    = {LOSS_W{1'b1}};

   typedef struct packed {
      logic signed [DATA_W-1:0] input_value;
      logic signed [DATA_W-1:0] target_value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [LOSS_W-1:0] loss_value;
      logic              is_reduced;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] abs_diff;
      logic              quad;
      logic              last;
   } q_entry_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

### rtl/smooth_l1_loss_reduce_core.sv
`timescale 1ns / 1ps
// smooth l1 loss with optional sum or mean reduction, q8.8 fixed point
// req channel: valid/stall, one prediction/target pair per word, word taken
//   when req_valid is high and req_stall is low
// rsp channel: valid/stall from a registered output; elementwise mode gives
//   one word per item, sum and mean give one word on the item marked last
// csr channel: valid/ready, always ready; index 0 beta, index 1 mode;
//   write only while no item is in flight
// a two-entry queue separates the input stage from the sequencer, so input
//   keeps flowing while a result waits on rsp_stall
// sequencing: a linear-region item passes S_LIN and S_ACC, a quadratic one
//   S_MUL, S_QSTART, S_QWAIT and S_ACC, and a mean close adds S_MSTART, S_MWAIT
// the sequencer works on one item at a time and pops the next from the queue
//   only once it is back in S_IDLE; the quadratic loss and the mean both use
//   the 41-step shared radix-2 divider
// reset: beta 1.0, elementwise mode, sum and count cleared, queue empty
// while rsp_stall holds, the result stays put and the sequencer waits, and
//   once the queue fills req_stall rises
module smooth_l1_loss_reduce_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  slrd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output slrd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slrd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slrd_pkg::DATA_W-1:0]       csr_data
);

   logic [slrd_pkg::DATA_W-1:0]  beta_ff, beta_in;
   logic [slrd_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic                         q_full;
   logic                         q_push;
   logic                         q_pop;
   logic                         q_valid;
   slrd_pkg::q_entry_type        push_entry;
   slrd_pkg::q_entry_type        pop_entry;
   slrd_pkg::div_req_type        div_req;
   slrd_pkg::div_rsp_type        div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      beta_in = beta_ff;
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            slrd_pkg::CSR_BETA: beta_in = csr_data;
            slrd_pkg::CSR_MODE: mode_in = csr_data[slrd_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= slrd_pkg::BETA_RESET;
         mode_ff <= slrd_pkg::MODE_ELEM;
      end else begin
         beta_ff <= beta_in;
         mode_ff <= mode_in;
      end
   end

   slrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .beta      (beta_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   slrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   slrd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   slrd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .beta           (beta_ff),
      .reduction_mode (mode_ff),
      .q_valid        (q_valid),
      .q_entry        (pop_entry),
      .q_pop          (q_pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule

### rtl/slrd_front.sv
`timescale 1ns / 1ps
module slrd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  slrd_pkg::req_type            req_data,
   input  logic [slrd_pkg::DATA_W-1:0]  beta,
   input  logic                         q_full,
   output logic                         q_push,
   output slrd_pkg::q_entry_type        q_entry
);

   logic                        valid_ff, valid_in;
   logic [slrd_pkg::DATA_W:0]   diff_ff, diff_in;
   logic                        last_ff, last_in;
   logic [slrd_pkg::DATA_W:0]   mag;
   logic                        take;

   assign req_stall = valid_ff && q_full;
   assign take      = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;

   always_comb begin
      diff_in  = {req_data.input_value[slrd_pkg::DATA_W-1], req_data.input_value}
               - {req_data.target_value[slrd_pkg::DATA_W-1], req_data.target_value};
      last_in  = req_data.last_element;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      mag = diff_ff[slrd_pkg::DATA_W] ? ((slrd_pkg::DATA_W+1)'(0) - diff_ff) : diff_ff;
      q_entry.abs_diff = mag[slrd_pkg::DATA_W-1:0];
      q_entry.quad     = mag[slrd_pkg::DATA_W-1:0] < beta;
      q_entry.last     = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         diff_ff <= diff_in;
         last_ff <= last_in;
      end
   end

endmodule

### rtl/slrd_queue.sv
`timescale 1ns / 1ps
module slrd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slrd_pkg::q_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output slrd_pkg::q_entry_type pop_entry
);

   slrd_pkg::q_entry_type             mem_ff [slrd_pkg::QUEUE_DEPTH];
   logic [slrd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [slrd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [slrd_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full      = count_ff == slrd_pkg::QCNT_W'(slrd_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/slrd_div.sv
`timescale 1ns / 1ps
module slrd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  slrd_pkg::div_req_type div_req,
   output slrd_pkg::div_rsp_type div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [slrd_pkg::DIV_CNT_W-1:0]    step_ff, step_in;
   logic [slrd_pkg::DIV_DEN_W-1:0]    den_ff, den_in;
   logic [slrd_pkg::DIV_DEN_W-1:0]    rem_ff, rem_in;
   logic [slrd_pkg::DIV_NUM_W-1:0]    q_ff, q_in;
   logic [slrd_pkg::DIV_DEN_W:0]      rem_sh;
   logic [slrd_pkg::DIV_DEN_W:0]      rem_sub;
   logic                              ge;

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[slrd_pkg::DIV_NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = slrd_pkg::DIV_CNT_W'(slrd_pkg::DIV_NUM_W - 1);
         den_in  = div_req.den;
         rem_in  = '0;
         q_in    = div_req.num;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[slrd_pkg::DIV_DEN_W-1:0] : rem_sh[slrd_pkg::DIV_DEN_W-1:0];
         q_in    = {q_ff[slrd_pkg::DIV_NUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

endmodule

### rtl/slrd_back.sv
`timescale 1ns / 1ps
module slrd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [slrd_pkg::DATA_W-1:0]   beta,
   input  logic [slrd_pkg::MODE_W-1:0]   reduction_mode,
   input  logic                          q_valid,
   input  slrd_pkg::q_entry_type         q_entry,
   output logic                          q_pop,
   output slrd_pkg::div_req_type         div_req,
   input  slrd_pkg::div_rsp_type         div_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output slrd_pkg::rsp_type             rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_LIN, S_MUL, S_QSTART, S_QWAIT, S_ACC, S_MSTART, S_MWAIT, S_OUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [slrd_pkg::DATA_W-1:0]        d_ff, d_in;
   logic                               last_ff, last_in;
   logic [slrd_pkg::DATA_W-1:0]        loss_ff, loss_in;
   logic [2*slrd_pkg::DATA_W-1:0]      prod_ff, prod_in;
   logic [slrd_pkg::LOSS_W-1:0]        sum_ff, sum_in;
   logic [slrd_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [slrd_pkg::LOSS_W-1:0]        res_ff, res_in;
   logic                               red_ff, red_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   slrd_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic [slrd_pkg::DATA_W+1:0]        lin;
   logic [slrd_pkg::LOSS_W:0]          sum_add;
   logic [slrd_pkg::LOSS_W-1:0]        sum_sat;
   logic [slrd_pkg::COUNT_W-1:0]       count_inc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      lin       = {1'b0, d_ff, 1'b1} - {2'b00, beta};
      sum_add   = {1'b0, sum_ff} + (slrd_pkg::LOSS_W+1)'(loss_ff);
      sum_sat   = sum_add[slrd_pkg::LOSS_W] ? slrd_pkg::SUM_MAX
                                            : sum_add[slrd_pkg::LOSS_W-1:0];
      count_inc = (count_ff < slrd_pkg::COUNT_W'(slrd_pkg::MAX_ELEMENTS))
                ? count_ff + 1'b1 : count_ff;

      state_in     = state_ff;
      d_in         = d_ff;
      last_in      = last_ff;
      loss_in      = loss_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      red_in       = red_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               d_in     = q_entry.abs_diff;
               last_in  = q_entry.last;
               state_in = q_entry.quad ? S_MUL : S_LIN;
            end
         end
         S_LIN: begin
            loss_in  = lin[slrd_pkg::DATA_W:1];
            state_in = S_ACC;
         end
         S_MUL: begin
            prod_in  = {{slrd_pkg::DATA_W{1'b0}}, d_ff} * {{slrd_pkg::DATA_W{1'b0}}, d_ff};
            state_in = S_QSTART;
         end
         S_QSTART: begin
            div_req.start = 1'b1;
            div_req.num   = slrd_pkg::DIV_NUM_W'(prod_ff) + slrd_pkg::DIV_NUM_W'(beta);
            div_req.den   = slrd_pkg::DIV_DEN_W'({beta, 1'b0});
            state_in      = S_QWAIT;
         end
         S_QWAIT: begin
            if (div_rsp.done) begin
               loss_in  = div_rsp.quot[slrd_pkg::DATA_W-1:0];
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (reduction_mode == slrd_pkg::MODE_ELEM) begin
               res_in   = slrd_pkg::LOSS_W'(loss_ff);
               red_in   = 1'b0;
               state_in = S_OUT;
            end else if (!last_ff) begin
               sum_in   = sum_sat;
               count_in = count_inc;
               state_in = S_IDLE;
            end else if (reduction_mode == slrd_pkg::MODE_MEAN) begin
               sum_in   = sum_sat;
               count_in = count_inc;
               state_in = S_MSTART;
            end else begin
               res_in   = sum_sat;
               red_in   = 1'b1;
               sum_in   = '0;
               count_in = '0;
               state_in = S_OUT;
            end
         end
         S_MSTART: begin
            div_req.start = 1'b1;
            div_req.num   = {1'b0, sum_ff} + slrd_pkg::DIV_NUM_W'(count_ff >> 1);
            div_req.den   = count_ff;
            sum_in        = '0;
            count_in      = '0;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quot[slrd_pkg::LOSS_W-1:0];
               red_in   = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.loss_value = res_ff;
               rsp_data_in.is_reduced = red_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
      d_ff        <= d_in;
      last_ff     <= last_in;
      loss_ff     <= loss_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      red_ff      <= red_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slrd_pkg::COUNT_W'(slrd_pkg::MAX_ELEMENTS))
      else $error("element count over limit");

   a_mean_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MSTART |=> sum_ff == '0 && count_ff == '0)
      else $error("sum not cleared after mean close");

   a_elem_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC && reduction_mode == slrd_pkg::MODE_ELEM |=> !red_ff)
      else $error("elementwise word marked reduced");

endmodule
